>>> hdl/dpalu_pkg.sv
// Package: shared types, opcodes and the rotate function for the data-processing ALU.
`timescale 1ns / 1ps

package dpalu_pkg;

  localparam int unsigned RegCount = 16;
  localparam int unsigned RegIdxW  = $clog2(RegCount);
  localparam int unsigned DataW    = 32;

  localparam logic [3:0] OpcAdd = 4'h4;
  localparam logic [3:0] OpcMov = 4'hD;

  typedef enum logic [1:0] {
    ShLsl = 2'd0,
    ShLsr = 2'd1,
    ShAsr = 2'd2,
    ShRor = 2'd3
  } shift_e;

  // Decoded instruction word held in the input stage.
  typedef struct packed {
    logic [3:0]         opcode;
    logic               imm_form;
    logic               set_flags;
    logic [RegIdxW-1:0] dest_reg;
    logic               shift_by_reg;
    logic [4:0]         shift_amount;
    shift_e             shift_type;
    logic [11:0]        imm_operand;
  } instr_t;

  // Execute outcome: register write plus flag state after the word.
  typedef struct packed {
    logic               written;
    logic [RegIdxW-1:0] result_reg;
    logic [DataW-1:0]   result_value;
    logic               neg_flag;
    logic               zero_flag;
  } exec_t;

  function automatic logic [DataW-1:0] ror32(input logic [DataW-1:0] x,
                                             input logic [4:0] s);
    logic [2*DataW-1:0] dbl;
    dbl = {x, x} >> s;
    return dbl[DataW-1:0];
  endfunction

endpackage

>>> hdl/dpalu_rf.sv
// Register file: two banks with valid bits, registered reads and write bypass.
`timescale 1ns / 1ps

module dpalu_rf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [dpalu_pkg::RegIdxW-1:0] rd_a_addr_i,
  input  logic [dpalu_pkg::RegIdxW-1:0] rd_b_addr_i,
  input  logic [dpalu_pkg::RegIdxW-1:0] rd_c_addr_i,
  input  logic                          wr_en_i,
  input  logic [dpalu_pkg::RegIdxW-1:0] wr_addr_i,
  input  logic [dpalu_pkg::DataW-1:0]   wr_data_i,
  output logic [dpalu_pkg::DataW-1:0]   rd_a_data_o,
  output logic [dpalu_pkg::DataW-1:0]   rd_b_data_o,
  output logic [dpalu_pkg::DataW-1:0]   rd_c_data_o
);
  import dpalu_pkg::*;

  // bank A serves ports a and b, bank B serves port c; both get every write
  logic [DataW-1:0]    bank_a_q [RegCount];
  logic [DataW-1:0]    bank_b_q [RegCount];
  logic [RegCount-1:0] vld_q;
  logic [DataW-1:0]    rd_a_q, rd_b_q, rd_c_q;
  logic [DataW-1:0]    rd_a_d, rd_b_d, rd_c_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      bank_a_q[wr_addr_i] <= wr_data_i;
      bank_b_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // unwritten entries read as zero; same-edge write wins
  always_comb begin
    rd_a_d = vld_q[rd_a_addr_i] ? bank_a_q[rd_a_addr_i] : '0;
    rd_b_d = vld_q[rd_b_addr_i] ? bank_a_q[rd_b_addr_i] : '0;
    rd_c_d = vld_q[rd_c_addr_i] ? bank_b_q[rd_c_addr_i] : '0;
    if (wr_en_i && (wr_addr_i == rd_a_addr_i)) rd_a_d = wr_data_i;
    if (wr_en_i && (wr_addr_i == rd_b_addr_i)) rd_b_d = wr_data_i;
    if (wr_en_i && (wr_addr_i == rd_c_addr_i)) rd_c_d = wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= rd_a_d;
      rd_b_q <= rd_b_d;
      rd_c_q <= rd_c_d;
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;
  assign rd_c_data_o = rd_c_q;

endmodule

>>> hdl/dpalu_exec.sv
// Execute logic: operand 2 barrel shifter, ADD/MOV and N/Z flag update.
`timescale 1ns / 1ps

module dpalu_exec (
  input  dpalu_pkg::instr_t             instr_i,
  input  logic [dpalu_pkg::DataW-1:0]   op1_i,
  input  logic [dpalu_pkg::DataW-1:0]   shift_val_i,
  input  logic [dpalu_pkg::DataW-1:0]   amount_val_i,
  input  logic                          neg_i,
  input  logic                          zero_i,
  output dpalu_pkg::exec_t              res_o
);
  import dpalu_pkg::*;

  logic [DataW-1:0] imm_rot;
  logic [7:0]       amt;
  logic             big;
  logic [DataW-1:0] sh_val;
  logic [DataW-1:0] op2;
  logic [DataW-1:0] sum;
  logic             wr;

  assign imm_rot = ror32({24'd0, instr_i.imm_operand[7:0]},
                         {instr_i.imm_operand[11:8], 1'b0});

  assign amt = instr_i.shift_by_reg ? amount_val_i[7:0] : {3'd0, instr_i.shift_amount};
  assign big = (amt[7:5] != 3'd0);

  always_comb begin
    case (instr_i.shift_type)
      ShLsl:   sh_val = big ? '0 : (shift_val_i << amt[4:0]);
      ShLsr:   sh_val = big ? '0 : (shift_val_i >> amt[4:0]);
      ShAsr:   sh_val = big ? {DataW{shift_val_i[DataW-1]}}
                            : DataW'($signed(shift_val_i) >>> amt[4:0]);
      default: sh_val = ror32(shift_val_i, amt[4:0]);
    endcase
  end

  assign op2 = instr_i.imm_form ? imm_rot : sh_val;
  assign sum = op1_i + op2;

  always_comb begin
    wr  = 1'b1;
    res_o.result_value = '0;
    unique case (instr_i.opcode)
      OpcAdd:  res_o.result_value = sum;
      OpcMov:  res_o.result_value = op2;
      default: wr = 1'b0;
    endcase
    res_o.written    = wr;
    res_o.result_reg = wr ? instr_i.dest_reg : '0;
    res_o.neg_flag   = neg_i;
    res_o.zero_flag  = zero_i;
    if (wr && instr_i.set_flags) begin
      res_o.neg_flag  = res_o.result_value[DataW-1];
      res_o.zero_flag = (res_o.result_value == '0);
    end
  end

endmodule

>>> hdl/arm_data_processing_alu.sv
// Top level: ARM data-processing ALU with barrel shifter and 16 x 32 register file.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one decoded data-processing
//   word per cycle while in_ready_o is high: opcode, operand-2 form, register indexes and shift fields.
//   Output channel (out_valid_o / out_ready_i) returns one word per input:
//   written flag, destination index, value written and the N/Z flags as they
//   stand after that instruction. Only ADD and MOV write; others report zero.
//   Order: the register file is read at accept into the input stage; once the
//   output register is free or being taken, shift, add and write-back go into
//   the output register and out_valid_o rises.
//   Throughput: 1 word per cycle while out_ready_i is high. A write at the
//   same edge as the next word's read is bypassed into that read, so
//   dependent words issue back to back.
//   Reset: all registers read as zero (per-entry valid bits), N/Z cleared,
//   both stages empty. There is no clearing pass.
//   Receiver stall: the output word holds; one more word waits in the input
//   stage, after which in_ready_o drops until the output is taken.
`timescale 1ns / 1ps

module arm_data_processing_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  opcode_i,
  input  logic        imm_form_i,
  input  logic        set_flags_i,
  input  logic [3:0]  first_reg_i,
  input  logic [3:0]  dest_reg_i,
  input  logic [3:0]  shifted_reg_i,
  input  logic [3:0]  amount_reg_i,
  input  logic        shift_by_reg_i,
  input  logic [4:0]  shift_amount_i,
  input  logic [1:0]  shift_type_i,
  input  logic [11:0] imm_operand_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        written_o,
  output logic [3:0]  result_reg_o,
  output logic [31:0] result_value_o,
  output logic        neg_flag_o,
  output logic        zero_flag_o
);
  import dpalu_pkg::*;

  // pipeline control
  logic   s1_vld_q, s1_vld_d;
  logic   out_vld_q, out_vld_d;
  logic   in_acc;
  logic   out_load_ok;
  logic   s1_adv;

  // input stage payload
  instr_t instr_q;
  instr_t instr_d;

  // register file read data, registered at accept
  logic [DataW-1:0] op1_val, shift_val, amount_val;

  // architectural flags
  logic   neg_q, zero_q;

  // execute outcome and output register
  exec_t  ex_res;
  exec_t  out_q;

  assign out_load_ok = !out_vld_q || out_ready_i;
  assign s1_adv      = s1_vld_q && out_load_ok;
  assign in_ready_o  = !s1_vld_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;

  assign s1_vld_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_q);
  assign out_vld_d = s1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    instr_d.opcode       = opcode_i;
    instr_d.imm_form     = imm_form_i;
    instr_d.set_flags    = set_flags_i;
    instr_d.dest_reg     = dest_reg_i;
    instr_d.shift_by_reg = shift_by_reg_i;
    instr_d.shift_amount = shift_amount_i;
    instr_d.shift_type   = shift_e'(shift_type_i);
    instr_d.imm_operand  = imm_operand_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      instr_q <= instr_d;
    end
  end

  // reads at accept; write-back happens when the input stage drains
  dpalu_rf u_rf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_a_addr_i (first_reg_i),
    .rd_b_addr_i (shifted_reg_i),
    .rd_c_addr_i (amount_reg_i),
    .wr_en_i     (s1_adv && ex_res.written),
    .wr_addr_i   (ex_res.result_reg),
    .wr_data_i   (ex_res.result_value),
    .rd_a_data_o (op1_val),
    .rd_b_data_o (shift_val),
    .rd_c_data_o (amount_val)
  );

  dpalu_exec u_exec (
    .instr_i      (instr_q),
    .op1_i        (op1_val),
    .shift_val_i  (shift_val),
    .amount_val_i (amount_val),
    .neg_i        (neg_q),
    .zero_i       (zero_q),
    .res_o        (ex_res)
  );

  // N/Z only move when a word retires into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q  <= 1'b0;
      zero_q <= 1'b0;
    end else if (s1_adv) begin
      neg_q  <= ex_res.neg_flag;
      zero_q <= ex_res.zero_flag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= ex_res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign written_o      = out_q.written;
  assign result_reg_o   = out_q.result_reg;
  assign result_value_o = out_q.result_value;
  assign neg_flag_o     = out_q.neg_flag;
  assign zero_flag_o    = out_q.zero_flag;

  // back-pressure only comes from a full input stage behind a stalled output
  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && out_vld_q && !out_ready_i))
    else $error("in_ready_o low without a stalled full pipeline");

  // a retiring word always shows up on the output next cycle
  a_retire_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_vld_q)
    else $error("retired word missing from output register");

  // output flags track the architectural flags while a word is shown
  a_flags_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (neg_flag_o == neg_q && zero_flag_o == zero_q))
    else $error("output flags differ from architectural flags");

  // non-writing words report zero index and value
  a_no_write_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !written_o) |-> (result_reg_o == 4'd0 && result_value_o == 32'd0))
    else $error("non-writing word carries nonzero result");

endmodule

>>> tb/sv/tb_arm_data_processing_alu.sv
// Testbench for the ARM data-processing ALU: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module tb_arm_data_processing_alu;
  import dpalu_pkg::*;

  // Opcodes the block ignores, used by name in the directed words.
  localparam logic [3:0] OpcAnd = 4'h0;
  localparam logic [3:0] OpcMvn = 4'hF;

  localparam int unsigned RandomWords   = 1775;
  localparam int unsigned PauseEvery    = 400;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned TailCycles    = 10;

  // One decoded instruction as the sender sees it.
  typedef struct packed {
    logic [3:0]  opcode;
    logic        imm_form;
    logic        set_flags;
    logic [3:0]  first_reg;
    logic [3:0]  dest_reg;
    logic [3:0]  shifted_reg;
    logic [3:0]  amount_reg;
    logic        shift_by_reg;
    logic [4:0]  shift_amount;
    shift_e      shift_type;
    logic [11:0] imm_operand;
  } word_t;

  // Tracks the register file and N/Z flags, and holds the expected exec words.
  class exec_board;
    logic [31:0] regs [16];
    logic        n_flag;
    logic        z_flag;
    exec_t       pending_exec [$];
    int unsigned fail_count;
    int unsigned n_words;
    int unsigned n_writes;
    int unsigned n_ignored;
    int unsigned n_wide_shift;

    function new();
      foreach (regs[i]) regs[i] = '0;
      n_flag = 1'b0;
      z_flag = 1'b0;
    endfunction

    function automatic logic [31:0] rotr(logic [31:0] x, logic [4:0] s);
      if (s == 5'd0) return x;
      return (x >> s) | (x << (6'd32 - s));
    endfunction

    // Barrel shifter output: rotated immediate or shifted register.
    function automatic logic [31:0] shifter_out(word_t w);
      logic [31:0] v;
      logic [7:0]  amt;
      if (w.imm_form) return rotr({24'd0, w.imm_operand[7:0]}, {w.imm_operand[11:8], 1'b0});
      v   = regs[w.shifted_reg];
      amt = w.shift_by_reg ? regs[w.amount_reg][7:0] : {3'd0, w.shift_amount};
      if (amt == 8'd0) return v;
      case (w.shift_type)
        ShLsl: return (amt >= 8'd32) ? 32'd0 : v << amt;
        ShLsr: return (amt >= 8'd32) ? 32'd0 : v >> amt;
        ShAsr: begin
          if (amt >= 8'd32) return {32{v[31]}};
          return $signed(v) >>> amt;
        end
        default: return rotr(v, amt[4:0]);
      endcase
    endfunction

    // Executes one accepted word; operands are read before the write-back.
    function void note_word(word_t w);
      exec_t       e;
      logic [31:0] op1;
      logic [31:0] op2;
      logic [31:0] res;
      n_words++;
      if (!w.imm_form && w.shift_by_reg && regs[w.amount_reg][7:0] >= 8'd32) n_wide_shift++;
      op2 = shifter_out(w);
      op1 = regs[w.first_reg];
      e   = '0;
      if (w.opcode == OpcAdd || w.opcode == OpcMov) begin
        res = (w.opcode == OpcAdd) ? op1 + op2 : op2;
        regs[w.dest_reg] = res;
        if (w.set_flags) begin
          n_flag = res[31];
          z_flag = (res == 32'd0);
        end
        e.written      = 1'b1;
        e.result_reg   = w.dest_reg;
        e.result_value = res;
        n_writes++;
      end else begin
        n_ignored++;
      end
      e.neg_flag  = n_flag;
      e.zero_flag = z_flag;
      pending_exec.push_back(e);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      fail_count++;
    endtask

    task check_exec(exec_t got);
      exec_t exp;
      if (pending_exec.size() == 0) begin
        report_mismatch($sformatf("unexpected word reg=%0d val=%h", got.result_reg,
                                  got.result_value));
        return;
      end
      exp = pending_exec.pop_front();
      if (got.written !== exp.written)
        report_mismatch($sformatf("written %b, want %b", got.written, exp.written));
      if (got.result_reg !== exp.result_reg)
        report_mismatch($sformatf("result_reg %0d, want %0d", got.result_reg, exp.result_reg));
      if (got.result_value !== exp.result_value)
        report_mismatch($sformatf("result_value %h, want %h", got.result_value,
                                  exp.result_value));
      if (got.neg_flag !== exp.neg_flag)
        report_mismatch($sformatf("N %b, want %b", got.neg_flag, exp.neg_flag));
      if (got.zero_flag !== exp.zero_flag)
        report_mismatch($sformatf("Z %b, want %b", got.zero_flag, exp.zero_flag));
    endtask
  endclass

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  logic        out_ready  = 1'b0;
  word_t       drv        = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        written_o;
  logic [3:0]  result_reg_o;
  logic [31:0] result_value_o;
  logic        neg_flag_o;
  logic        zero_flag_o;

  exec_board   board = new();
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;

  arm_data_processing_alu u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .opcode_i      (drv.opcode),
    .imm_form_i    (drv.imm_form),
    .set_flags_i   (drv.set_flags),
    .first_reg_i   (drv.first_reg),
    .dest_reg_i    (drv.dest_reg),
    .shifted_reg_i (drv.shifted_reg),
    .amount_reg_i  (drv.amount_reg),
    .shift_by_reg_i(drv.shift_by_reg),
    .shift_amount_i(drv.shift_amount),
    .shift_type_i  (drv.shift_type),
    .imm_operand_i (drv.imm_operand),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .written_o     (written_o),
    .result_reg_o  (result_reg_o),
    .result_value_o(result_value_o),
    .neg_flag_o    (neg_flag_o),
    .zero_flag_o   (zero_flag_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Both channels sampled at the edge; the board sees inputs before outputs,
  // which is harmless since an output always belongs to an older word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) board.note_word(drv);
      if (out_valid_o && out_ready)
        board.check_exec('{written_o, result_reg_o, result_value_o, neg_flag_o, zero_flag_o});
    end
  end

  // Receiver stall pattern: the mode is redrawn periodically at random among full
  // speed, random stalls, a periodic stall and long periodic stalls.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 9) < 6);
      2:       out_ready <= (rx_cycle % 4 != 0);
      default: out_ready <= (rx_cycle % 32 >= 20);
    endcase
  end

  // Watchdog: too many cycles with no handshake on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic word_t imm_op(logic [3:0] opc, logic s, logic [3:0] dest,
                                   logic [3:0] first, logic [11:0] imm);
    word_t w;
    w             = word_t'({$urandom, $urandom});
    w.opcode      = opc;
    w.imm_form    = 1'b1;
    w.set_flags   = s;
    w.dest_reg    = dest;
    w.first_reg   = first;
    w.imm_operand = imm;
    return w;
  endfunction

  function automatic word_t reg_op(logic [3:0] opc, logic s, logic [3:0] dest,
                                   logic [3:0] first, logic [3:0] sreg, shift_e st,
                                   logic by_reg, logic [3:0] areg, logic [4:0] amt);
    word_t w;
    w              = word_t'({$urandom, $urandom});
    w.opcode       = opc;
    w.imm_form     = 1'b0;
    w.set_flags    = s;
    w.dest_reg     = dest;
    w.first_reg    = first;
    w.shifted_reg  = sreg;
    w.shift_type   = st;
    w.shift_by_reg = by_reg;
    w.amount_reg   = areg;
    w.shift_amount = amt;
    return w;
  endfunction

  // Mostly ADD/MOV with random content; small immediates seed shift amounts
  // near 32 into the register file, the rest is ignored-opcode noise.
  function automatic word_t rand_word();
    word_t       w;
    int unsigned r;
    w = word_t'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 45)      w.opcode = OpcAdd;
    else if (r < 88) w.opcode = OpcMov;
    w.imm_form = ($urandom_range(0, 9) < 4);
    if (w.imm_form && $urandom_range(0, 3) == 0) w.imm_operand = 12'($urandom_range(0, 40));
    if ($urandom_range(0, 9) == 0) w.shift_amount = $urandom_range(0, 1) ? 5'd31 : 5'd0;
    return w;
  endfunction

  // Sends one word, holds it until accepted, then plays out the sender's
  // burst/gap pattern. Valid is only lowered when a gap actually follows.
  task issue(word_t w);
    drv      <= w;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  // Sender holds off until every expected word has come back.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_exec.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned rand_words;
    word_t       w;

    rand_words = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: seed registers with edge values, then walk the shifter corners.
    issue(imm_op(OpcMov, 1'b1, 4'd1, 4'd0, 12'h0FF));   // r1 = 0xFF, also amount 255
    issue(imm_op(OpcMov, 1'b1, 4'd2, 4'd0, 12'h102));   // r2 = 0x80000000, N set
    issue(imm_op(OpcMov, 1'b0, 4'd3, 4'd0, 12'hFFF));   // widest rotate
    issue(imm_op(OpcMov, 1'b1, 4'd4, 4'd0, 12'h000));   // zero result, Z set
    issue(reg_op(OpcMov, 1'b0, 4'd5, 4'd0, 4'd2, ShAsr, 1'b0, 4'd0, 5'd31)); // all ones
    issue(imm_op(OpcMov, 1'b0, 4'd6, 4'd0, 12'h020));   // amount 32
    issue(imm_op(OpcMov, 1'b0, 4'd9, 4'd0, 12'h021));   // amount 33
    issue(reg_op(OpcMov, 1'b1, 4'd8, 4'd0, 4'd5, ShLsl, 1'b1, 4'd6, 5'd0));  // LSL 32
    issue(reg_op(OpcMov, 1'b1, 4'd8, 4'd0, 4'd5, ShLsr, 1'b1, 4'd1, 5'd0));  // LSR 255
    issue(reg_op(OpcMov, 1'b1, 4'd10, 4'd0, 4'd2, ShAsr, 1'b1, 4'd6, 5'd0)); // ASR neg 32
    issue(reg_op(OpcMov, 1'b1, 4'd10, 4'd0, 4'd1, ShAsr, 1'b1, 4'd1, 5'd0)); // ASR pos 255
    issue(reg_op(OpcMov, 1'b0, 4'd11, 4'd0, 4'd2, ShRor, 1'b1, 4'd6, 5'd0)); // ROR 32
    issue(reg_op(OpcMov, 1'b0, 4'd11, 4'd0, 4'd1, ShRor, 1'b1, 4'd9, 5'd0)); // ROR 33
    issue(reg_op(OpcMov, 1'b0, 4'd12, 4'd0, 4'd5, ShLsr, 1'b0, 4'd0, 5'd0)); // LSR #0
    issue(reg_op(OpcMov, 1'b0, 4'd12, 4'd0, 4'd2, ShAsr, 1'b0, 4'd0, 5'd0)); // ASR #0
    issue(reg_op(OpcMov, 1'b0, 4'd12, 4'd0, 4'd3, ShRor, 1'b0, 4'd0, 5'd0)); // ROR #0
    issue(reg_op(OpcMov, 1'b1, 4'd13, 4'd0, 4'd1, ShLsl, 1'b0, 4'd0, 5'd31));
    issue(reg_op(OpcMov, 1'b1, 4'd13, 4'd0, 4'd5, ShLsr, 1'b0, 4'd0, 5'd31));
    issue(reg_op(OpcAdd, 1'b1, 4'd14, 4'd5, 4'd1, ShLsl, 1'b0, 4'd0, 5'd0)); // wraps
    issue(reg_op(OpcAdd, 1'b1, 4'd1, 4'd1, 4'd1, ShLsl, 1'b0, 4'd0, 5'd1));  // rd = rn = rm
    issue(reg_op(OpcAdd, 1'b0, 4'd15, 4'd5, 4'd4, ShLsl, 1'b0, 4'd0, 5'd0)); // flags kept
    issue(reg_op(OpcAnd, 1'b1, 4'd3, 4'd5, 4'd5, ShLsl, 1'b0, 4'd0, 5'd0));  // ignored
    issue(reg_op(OpcMvn, 1'b1, 4'd3, 4'd5, 4'd5, ShLsl, 1'b0, 4'd0, 5'd0));  // ignored
    issue(imm_op(OpcAdd, 1'b1, 4'd15, 4'd2, 12'h4FF));  // ADD with rotated immediate
    issue(imm_op(OpcAdd, 1'b1, 4'd0, 4'd5, 12'h001));   // sums to zero
    drain();

    // Random: fixed word count, pause to empty now and then.
    while (rand_words < RandomWords) begin
      w = rand_word();
      issue(w);
      rand_words++;
      if (rand_words % PauseEvery == 0) drain();
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_exec.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d words: %0d register writes, %0d ignored opcodes.",
             board.n_words, board.n_writes, board.n_ignored);
    $display("Shift-by-register with amount 32 or more: %0d; mismatches: %0d.",
             board.n_wide_shift, board.fail_count);
    if (board.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
